FILE: design/skas_pkg.sv
// session keepalive supervisor: shared types, codes and default values
// no dependencies; imported by the core and by its checker
package skas_pkg;

  // default sizes handed to the core parameters
  localparam int SESSIONS_DEF  = 16;
  localparam int TIME_BITS_DEF = 32;

  // fixed port and field widths
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_W     = 4;
  localparam int MODE_W    = 2;
  localparam int STATE_W   = 3;
  localparam int CALL_W    = 2;
  localparam int TOTAL_W   = 5;
  localparam int LIMIT_W   = 8;
  localparam int ATT_W     = 8;
  localparam int NOW_W     = 32;
  // doubled delay stays below twice the cap
  localparam int DELAY_W   = CFG_W + 1;

  // request kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_CONNECT    = 2'd0,
    MODE_DISCONNECT = 2'd1,
    MODE_TOUCH      = 2'd2,
    MODE_TICK       = 2'd3
  } mode_t;

  // session states as reported on the result channel
  typedef enum logic [STATE_W-1:0] {
    SS_DISCONNECTED = 3'd0,
    SS_CONNECTING   = 3'd1,
    SS_CONNECTED    = 3'd2,
    SS_RECONNECTING = 3'd3,
    SS_FAILED       = 3'd4
  } sess_state_t;

  // driver call issued by a request
  typedef enum logic [CALL_W-1:0] {
    CALL_NONE      = 2'd0,
    CALL_ESTABLISH = 2'd1,
    CALL_PROBE     = 2'd2
  } call_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BO_BASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BO_CAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ATT_LIMIT = 3'd4;

  // configuration reset values
  localparam logic [CFG_W-1:0]   KEEPALIVE_RST = 32'd30000;
  localparam logic [CFG_W-1:0]   IDLE_TO_RST   = 32'd120000;
  localparam logic [CFG_W-1:0]   BO_BASE_RST   = 32'd1000;
  localparam logic [CFG_W-1:0]   BO_CAP_RST    = 32'd60000;
  localparam logic [LIMIT_W-1:0] ATT_LIMIT_RST = 8'd5;

  // saturation value of the stored attempt count
  localparam logic [ATT_W-1:0] ATT_MAX = {ATT_W{1'b1}};

  // sequencer steps
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_READ,
    SQ_EVAL,
    SQ_IDLE_CHK,
    SQ_BACKOFF,
    SQ_RETRY,
    SQ_COMMIT
  } seq_t;

endpackage

FILE: design/session_keepalive_supervisor_core.sv
// session keepalive supervisor: session table, sequencer and shared time unit
// depends on skas_pkg
//
// Usage:
//  - in_* is the request channel (valid/ready). A request names a session and
//    carries the mode, the current time and the outcome of the driver call
//    that it triggers. out_* is the result channel (valid/ready), one result
//    per request. cfg_* writes one configuration register per cycle; the
//    user must write only while the block is idle, the block does not enforce it.
//  - One request at a time: in_ready is high only while the sequencer waits.
//    A request passes the table read, evaluate and commit steps before the
//    sequencer waits again; a tick may also run the idle check, a retry time
//    may be computed in a retry step, and a backoff step runs once per
//    doubling (at most the attempt number minus one doublings) plus once to
//    clamp. The single subtract/add-and-compare time unit and the one-port
//    session memory make these steps run one after another.
//  - The result is visible in the cycle after the commit step and waits in the
//    output register; the next request may be accepted and evaluated
//    meanwhile, and its commit waits until the receiver takes the result.
//  - Synchronous reset clears all sessions (valid bits), the live counts,
//    the output valid bit and restores the configuration defaults.
module session_keepalive_supervisor_core #(
  parameter int SESSIONS  = skas_pkg::SESSIONS_DEF,
  parameter int TIME_BITS = skas_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [skas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [skas_pkg::CFG_W-1:0]      cfg_wdata,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [skas_pkg::MODE_W-1:0]     in_mode,
  input  logic [skas_pkg::IDX_W-1:0]      in_session_index,
  input  logic [skas_pkg::NOW_W-1:0]      in_now,
  input  logic                            in_link_ok,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [skas_pkg::STATE_W-1:0]    out_session_state,
  output logic                            out_present,
  output logic                            out_first_event_valid,
  output logic [skas_pkg::STATE_W-1:0]    out_first_event_state,
  output logic                            out_second_event_valid,
  output logic [skas_pkg::STATE_W-1:0]    out_second_event_state,
  output logic [skas_pkg::CALL_W-1:0]     out_driver_call,
  output logic                            out_connect_failed,
  output logic [skas_pkg::TOTAL_W-1:0]    out_connected_total,
  output logic [skas_pkg::TOTAL_W-1:0]    out_reconnecting_total
);
  import skas_pkg::*;

  // derived sizes
  localparam int AW     = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int IXW    = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int CNTW   = $clog2(SESSIONS + 1);
  localparam int TOTW   = (CNTW > TOTAL_W) ? CNTW : TOTAL_W;
  localparam int CMPW   = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int EXTW   = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;
  localparam int ITER_W = ATT_W + 1;

  // configuration registers
  logic [CFG_W-1:0]   cfg_keepalive_r, cfg_idle_r, cfg_base_r, cfg_cap_r;
  logic [LIMIT_W-1:0] cfg_limit_r;

  // sequencer
  seq_t seq_r, seq_nxt;

  // latched request
  mode_t               mode_r, mode_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic                in_range_r, in_range_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic                ok_r, ok_nxt;

  // session table: valid bits in flops, the rest in memory
  logic [SESSIONS-1:0]  entry_valid_r;
  sess_state_t          state_mem [SESSIONS];
  logic [TIME_BITS-1:0] act_mem   [SESSIONS];
  logic [TIME_BITS-1:0] probe_mem [SESSIONS];
  logic [TIME_BITS-1:0] retry_mem [SESSIONS];
  logic [ATT_W-1:0]     att_mem   [SESSIONS];
  sess_state_t          rd_state_r;
  logic [TIME_BITS-1:0] rd_act_r, rd_probe_r, rd_retry_r;
  logic [ATT_W-1:0]     rd_att_r;
  logic                 mem_we;

  // working copy of the entry
  logic                 vld_w_r, vld_w_nxt;
  sess_state_t          st_w_r, st_w_nxt;
  logic [TIME_BITS-1:0] act_w_r, act_w_nxt;
  logic [TIME_BITS-1:0] probe_w_r, probe_w_nxt;
  logic [TIME_BITS-1:0] retry_w_r, retry_w_nxt;
  logic [ATT_W-1:0]     att_w_r, att_w_nxt;

  // backoff iteration
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic [ITER_W-1:0]  iter_r, iter_nxt;
  logic [ITER_W-1:0]  att9_r, att9_nxt;
  logic               retry_pend_r, retry_pend_nxt;

  // per-request report
  call_t       call_r, call_nxt;
  logic        cfail_r, cfail_nxt;
  logic        ev0_v_r, ev0_v_nxt, ev1_v_r, ev1_v_nxt;
  sess_state_t ev0_s_r, ev0_s_nxt, ev1_s_r, ev1_s_nxt;

  // live counts
  logic [CNTW-1:0] conn_cnt_r, conn_cnt_nxt;
  logic [CNTW-1:0] recon_cnt_r, recon_cnt_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  sess_state_t        out_state_r, out_state_nxt;
  logic               out_present_r, out_present_nxt;
  logic               out_ev0_v_r, out_ev0_v_nxt, out_ev1_v_r, out_ev1_v_nxt;
  sess_state_t        out_ev0_s_r, out_ev0_s_nxt, out_ev1_s_r, out_ev1_s_nxt;
  call_t              out_call_r, out_call_nxt;
  logic               out_cfail_r, out_cfail_nxt;
  logic [TOTAL_W-1:0] out_conn_r, out_conn_nxt, out_recon_r, out_recon_nxt;

  // shared time unit
  logic                 u_sub;
  logic [TIME_BITS-1:0] u_b, u_res;
  logic [CFG_W-1:0]     u_span;
  logic                 u_neg, u_ge;

  // request decode helpers
  logic [IXW-1:0]       idx_ext;
  logic [EXTW-1:0]      now_ext, dly_ext;
  logic                 cur_vld, tick_conn, tick_recon, probe_due, retry_ok;
  logic [ITER_W-1:0]    att_inc;
  logic                 att_over, boff_cont, out_free, commit_go;
  logic                 old_conn, old_recon, new_conn, new_recon;
  logic [TOTW-1:0]      conn_wide, recon_wide;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_keepalive_r <= KEEPALIVE_RST;
      cfg_idle_r      <= IDLE_TO_RST;
      cfg_base_r      <= BO_BASE_RST;
      cfg_cap_r       <= BO_CAP_RST;
      cfg_limit_r     <= ATT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEEPALIVE: cfg_keepalive_r <= cfg_wdata;
        CFG_IDLE_TO:   cfg_idle_r      <= cfg_wdata;
        CFG_BO_BASE:   cfg_base_r      <= cfg_wdata;
        CFG_BO_CAP:    cfg_cap_r       <= cfg_wdata;
        CFG_ATT_LIMIT: cfg_limit_r     <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // request decode and decision terms
  always_comb begin
    idx_ext    = IXW'(in_session_index);
    now_ext    = EXTW'(in_now);
    dly_ext    = EXTW'(delay_r);
    cur_vld    = in_range_r && entry_valid_r[addr_r];
    tick_conn  = (mode_r == MODE_TICK) && cur_vld && (rd_state_r == SS_CONNECTED);
    tick_recon = (mode_r == MODE_TICK) && cur_vld && (rd_state_r == SS_RECONNECTING);
    probe_due  = !u_neg && u_ge;
    retry_ok   = !u_neg;
    att_inc    = {1'b0, rd_att_r} + ITER_W'(1);
    att_over   = att_inc > {1'b0, cfg_limit_r};
    boff_cont  = (iter_r < att9_r) && (delay_r < {1'b0, cfg_cap_r});
    out_free   = !out_valid_r || out_ready;
    commit_go  = (seq_r == SQ_COMMIT) && out_free;
    mem_we     = commit_go && in_range_r;
  end

  // shared time unit: now minus a stamp (with span compare) or now plus a delay
  always_comb begin
    u_sub  = 1'b1;
    u_b    = rd_probe_r;
    u_span = cfg_keepalive_r;
    unique case (seq_r)
      SQ_EVAL: begin
        if (rd_state_r == SS_CONNECTED) begin
          u_b    = rd_probe_r;
          u_span = cfg_keepalive_r;
        end else begin
          u_b    = rd_retry_r;
          u_span = '0;
        end
      end
      SQ_IDLE_CHK: begin
        u_b    = act_w_r;
        u_span = cfg_idle_r;
      end
      SQ_RETRY: begin
        u_sub  = 1'b0;
        u_b    = dly_ext[TIME_BITS-1:0];
        u_span = '0;
      end
      default: ;
    endcase
    u_res = u_sub ? (now_r - u_b) : (now_r + u_b);
    u_neg = u_res[TIME_BITS-1];
    u_ge  = CMPW'(u_res) >= CMPW'(u_span);
  end

  // next step of the sequencer
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      SQ_IDLE:  if (in_valid) seq_nxt = SQ_READ;
      SQ_READ:  seq_nxt = SQ_EVAL;
      SQ_EVAL: begin
        priority if (!in_range_r)
          seq_nxt = SQ_COMMIT;
        else if (mode_r == MODE_CONNECT)
          seq_nxt = ok_r ? SQ_COMMIT : SQ_RETRY;
        else if (tick_conn)
          seq_nxt = SQ_IDLE_CHK;
        else if (tick_recon && retry_ok && !att_over && !ok_r)
          seq_nxt = SQ_BACKOFF;
        else
          seq_nxt = SQ_COMMIT;
      end
      SQ_IDLE_CHK: seq_nxt = retry_pend_r ? SQ_RETRY : SQ_COMMIT;
      SQ_BACKOFF:  seq_nxt = boff_cont ? SQ_BACKOFF : SQ_RETRY;
      SQ_RETRY:    seq_nxt = SQ_COMMIT;
      SQ_COMMIT:   if (out_free) seq_nxt = SQ_IDLE;
      default:     seq_nxt = SQ_IDLE;
    endcase
  end

  // datapath updates per step
  always_comb begin
    mode_nxt       = mode_r;
    addr_nxt       = addr_r;
    in_range_nxt   = in_range_r;
    now_nxt        = now_r;
    ok_nxt         = ok_r;
    vld_w_nxt      = vld_w_r;
    st_w_nxt       = st_w_r;
    act_w_nxt      = act_w_r;
    probe_w_nxt    = probe_w_r;
    retry_w_nxt    = retry_w_r;
    att_w_nxt      = att_w_r;
    delay_nxt      = delay_r;
    iter_nxt       = iter_r;
    att9_nxt       = att9_r;
    retry_pend_nxt = retry_pend_r;
    call_nxt       = call_r;
    cfail_nxt      = cfail_r;
    ev0_v_nxt      = ev0_v_r;
    ev0_s_nxt      = ev0_s_r;
    ev1_v_nxt      = ev1_v_r;
    ev1_s_nxt      = ev1_s_r;

    unique case (seq_r)
      // latch the request
      SQ_IDLE: begin
        if (in_valid) begin
          mode_nxt     = mode_t'(in_mode);
          addr_nxt     = idx_ext[AW-1:0];
          in_range_nxt = idx_ext < IXW'(SESSIONS);
          now_nxt      = now_ext[TIME_BITS-1:0];
          ok_nxt       = in_link_ok;
        end
      end

      // apply the request to the entry just read
      SQ_EVAL: begin
        vld_w_nxt      = cur_vld;
        st_w_nxt       = rd_state_r;
        act_w_nxt      = rd_act_r;
        probe_w_nxt    = rd_probe_r;
        retry_w_nxt    = rd_retry_r;
        att_w_nxt      = rd_att_r;
        delay_nxt      = DELAY_W'(cfg_base_r);
        iter_nxt       = ITER_W'(1);
        att9_nxt       = att_inc;
        retry_pend_nxt = 1'b0;
        call_nxt       = CALL_NONE;
        cfail_nxt      = 1'b0;
        ev0_v_nxt      = 1'b0;
        ev0_s_nxt      = SS_DISCONNECTED;
        ev1_v_nxt      = 1'b0;
        ev1_s_nxt      = SS_DISCONNECTED;
        if (in_range_r) begin
          unique case (mode_r)
            MODE_CONNECT: begin
              vld_w_nxt = 1'b1;
              att_w_nxt = '0;
              call_nxt  = CALL_ESTABLISH;
              ev0_v_nxt = 1'b1;
              if (ok_r) begin
                st_w_nxt    = SS_CONNECTED;
                act_w_nxt   = now_r;
                probe_w_nxt = now_r;
                ev0_s_nxt   = SS_CONNECTED;
              end else begin
                st_w_nxt  = SS_FAILED;
                cfail_nxt = 1'b1;
                ev0_s_nxt = SS_FAILED;
              end
            end
            MODE_DISCONNECT: begin
              if (cur_vld) begin
                vld_w_nxt = 1'b0;
                st_w_nxt  = SS_DISCONNECTED;
                ev0_v_nxt = 1'b1;
                ev0_s_nxt = SS_DISCONNECTED;
              end
            end
            MODE_TOUCH: begin
              if (cur_vld) act_w_nxt = now_r;
            end
            MODE_TICK: begin
              if (tick_conn && probe_due) begin
                call_nxt    = CALL_PROBE;
                probe_w_nxt = now_r;
                if (ok_r) begin
                  act_w_nxt = now_r;
                end else begin
                  st_w_nxt       = SS_RECONNECTING;
                  att_w_nxt      = '0;
                  ev0_v_nxt      = 1'b1;
                  ev0_s_nxt      = SS_RECONNECTING;
                  retry_pend_nxt = 1'b1;
                end
              end else if (tick_recon && retry_ok) begin
                att_w_nxt = att_inc[ATT_W] ? ATT_MAX : att_inc[ATT_W-1:0];
                if (att_over) begin
                  st_w_nxt  = SS_FAILED;
                  ev0_v_nxt = 1'b1;
                  ev0_s_nxt = SS_FAILED;
                end else begin
                  call_nxt = CALL_ESTABLISH;
                  if (ok_r) begin
                    st_w_nxt    = SS_CONNECTED;
                    act_w_nxt   = now_r;
                    probe_w_nxt = now_r;
                    att_w_nxt   = '0;
                    ev0_v_nxt   = 1'b1;
                    ev0_s_nxt   = SS_CONNECTED;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end

      // idle timeout on a connected session, after any probe
      SQ_IDLE_CHK: begin
        if (!u_neg && u_ge) begin
          st_w_nxt = SS_DISCONNECTED;
          if (ev0_v_r) begin
            ev1_v_nxt = 1'b1;
            ev1_s_nxt = SS_DISCONNECTED;
          end else begin
            ev0_v_nxt = 1'b1;
            ev0_s_nxt = SS_DISCONNECTED;
          end
        end
      end

      // one doubling per cycle, clamp to the cap on exit
      SQ_BACKOFF: begin
        if (boff_cont) begin
          delay_nxt = {delay_r[DELAY_W-2:0], 1'b0};
          iter_nxt  = iter_r + ITER_W'(1);
        end else if (delay_r >= {1'b0, cfg_cap_r}) begin
          delay_nxt = {1'b0, cfg_cap_r};
        end
      end

      // retry time from the shared adder
      SQ_RETRY: retry_w_nxt = u_res;

      default: ;
    endcase
  end

  // live count deltas and result fields
  always_comb begin
    old_conn  = cur_vld && (rd_state_r == SS_CONNECTED);
    old_recon = cur_vld && (rd_state_r == SS_RECONNECTING);
    new_conn  = vld_w_r && (st_w_r == SS_CONNECTED);
    new_recon = vld_w_r && (st_w_r == SS_RECONNECTING);

    conn_cnt_nxt  = conn_cnt_r;
    recon_cnt_nxt = recon_cnt_r;
    if (commit_go) begin
      conn_cnt_nxt  = conn_cnt_r + CNTW'(new_conn) - CNTW'(old_conn);
      recon_cnt_nxt = recon_cnt_r + CNTW'(new_recon) - CNTW'(old_recon);
    end
    conn_wide  = TOTW'(conn_cnt_nxt);
    recon_wide = TOTW'(recon_cnt_nxt);

    out_valid_nxt   = out_valid_r && !out_ready;
    out_state_nxt   = out_state_r;
    out_present_nxt = out_present_r;
    out_ev0_v_nxt   = out_ev0_v_r;
    out_ev0_s_nxt   = out_ev0_s_r;
    out_ev1_v_nxt   = out_ev1_v_r;
    out_ev1_s_nxt   = out_ev1_s_r;
    out_call_nxt    = out_call_r;
    out_cfail_nxt   = out_cfail_r;
    out_conn_nxt    = out_conn_r;
    out_recon_nxt   = out_recon_r;
    if (commit_go) begin
      out_valid_nxt   = 1'b1;
      out_state_nxt   = vld_w_r ? st_w_r : SS_DISCONNECTED;
      out_present_nxt = vld_w_r;
      out_ev0_v_nxt   = ev0_v_r;
      out_ev0_s_nxt   = ev0_s_r;
      out_ev1_v_nxt   = ev1_v_r;
      out_ev1_s_nxt   = ev1_s_r;
      out_call_nxt    = call_r;
      out_cfail_nxt   = cfail_r;
      out_conn_nxt    = conn_wide[TOTAL_W-1:0];
      out_recon_nxt   = recon_wide[TOTAL_W-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r         <= SQ_IDLE;
      entry_valid_r <= '0;
      conn_cnt_r    <= '0;
      recon_cnt_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      conn_cnt_r  <= conn_cnt_nxt;
      recon_cnt_r <= recon_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) entry_valid_r[addr_r] <= vld_w_r;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    mode_r         <= mode_nxt;
    addr_r         <= addr_nxt;
    in_range_r     <= in_range_nxt;
    now_r          <= now_nxt;
    ok_r           <= ok_nxt;
    vld_w_r        <= vld_w_nxt;
    st_w_r         <= st_w_nxt;
    act_w_r        <= act_w_nxt;
    probe_w_r      <= probe_w_nxt;
    retry_w_r      <= retry_w_nxt;
    att_w_r        <= att_w_nxt;
    delay_r        <= delay_nxt;
    iter_r         <= iter_nxt;
    att9_r         <= att9_nxt;
    retry_pend_r   <= retry_pend_nxt;
    call_r         <= call_nxt;
    cfail_r        <= cfail_nxt;
    ev0_v_r        <= ev0_v_nxt;
    ev0_s_r        <= ev0_s_nxt;
    ev1_v_r        <= ev1_v_nxt;
    ev1_s_r        <= ev1_s_nxt;
    out_state_r    <= out_state_nxt;
    out_present_r  <= out_present_nxt;
    out_ev0_v_r    <= out_ev0_v_nxt;
    out_ev0_s_r    <= out_ev0_s_nxt;
    out_ev1_v_r    <= out_ev1_v_nxt;
    out_ev1_s_r    <= out_ev1_s_nxt;
    out_call_r     <= out_call_nxt;
    out_cfail_r    <= out_cfail_nxt;
    out_conn_r     <= out_conn_nxt;
    out_recon_r    <= out_recon_nxt;
  end

  // session memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      state_mem[addr_r] <= st_w_r;
      act_mem[addr_r]   <= act_w_r;
      probe_mem[addr_r] <= probe_w_r;
      retry_mem[addr_r] <= retry_w_r;
      att_mem[addr_r]   <= att_w_r;
    end
    if (seq_r == SQ_READ) begin
      rd_state_r <= state_mem[addr_r];
      rd_act_r   <= act_mem[addr_r];
      rd_probe_r <= probe_mem[addr_r];
      rd_retry_r <= retry_mem[addr_r];
      rd_att_r   <= att_mem[addr_r];
    end
  end

  // port drive
  assign in_ready               = (seq_r == SQ_IDLE);
  assign out_valid              = out_valid_r;
  assign out_session_state      = out_state_r;
  assign out_present            = out_present_r;
  assign out_first_event_valid  = out_ev0_v_r;
  assign out_first_event_state  = out_ev0_s_r;
  assign out_second_event_valid = out_ev1_v_r;
  assign out_second_event_state = out_ev1_s_r;
  assign out_driver_call        = out_call_r;
  assign out_connect_failed     = out_cfail_r;
  assign out_connected_total    = out_conn_r;
  assign out_reconnecting_total = out_recon_r;

endmodule

FILE: design/skas_checker.sv
// port-level checks for the session keepalive supervisor, bound to the core
// depends on skas_pkg and session_keepalive_supervisor_core
module skas_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [skas_pkg::STATE_W-1:0]    out_session_state,
  input logic                            out_present,
  input logic                            out_first_event_valid,
  input logic [skas_pkg::STATE_W-1:0]    out_first_event_state,
  input logic                            out_second_event_valid,
  input logic [skas_pkg::STATE_W-1:0]    out_second_event_state,
  input logic [skas_pkg::CALL_W-1:0]     out_driver_call,
  input logic                            out_connect_failed,
  input logic [skas_pkg::TOTAL_W-1:0]    out_connected_total
);
  import skas_pkg::*;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one request at a time: busy the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted twice in a row");

  // two events only from a failed probe followed by an idle timeout
  a_two_events: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_second_event_valid |->
      out_first_event_valid && (out_first_event_state == SS_RECONNECTING) &&
      (out_second_event_state == SS_DISCONNECTED) &&
      (out_driver_call == CALL_PROBE) && out_present)
    else $error("second event without probe failure and timeout");

  // failed connect: establish issued, session kept as failed
  a_connect_failed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_connect_failed |->
      (out_driver_call == CALL_ESTABLISH) && out_first_event_valid &&
      (out_first_event_state == SS_FAILED) && out_present &&
      (out_session_state == SS_FAILED))
    else $error("connect failure reported inconsistently");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_session_state) && $stable(out_connected_total))
    else $error("result changed while stalled");

endmodule

bind session_keepalive_supervisor_core skas_checker u_skas_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_ready               (in_ready),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_session_state      (out_session_state),
  .out_present            (out_present),
  .out_first_event_valid  (out_first_event_valid),
  .out_first_event_state  (out_first_event_state),
  .out_second_event_valid (out_second_event_valid),
  .out_second_event_state (out_second_event_state),
  .out_driver_call        (out_driver_call),
  .out_connect_failed     (out_connect_failed),
  .out_connected_total    (out_connected_total)
);
